// ===== hdl/previous_smaller_element_core_defines.svh =====
// ----------------------------------------------------------------------------
// previous smaller element core: assertion macros
// Shared concurrent assertion forms, sampled on the block clock and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PREVIOUS_SMALLER_ELEMENT_CORE_DEFINES_SVH
`define PREVIOUS_SMALLER_ELEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define PSE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pse assertion failed");

// next-cycle implication
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pse assertion failed");

`endif

// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Constants shared by the previous smaller element core modules.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int STACK_DEPTH_DEF = 256;

    // entries in the queue between front and engine
    localparam int QUEUE_DEPTH = 4;

    // tuser bit positions
    localparam int IN_START_BIT  = 0;
    localparam int OUT_FOUND_BIT = 0;
    localparam int OUT_OVF_BIT   = 1;

endpackage

// ===== hdl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front
// Accepts input transactions, splits them into value and start flag and
// holds them in a short queue for the stack engine.
// ----------------------------------------------------------------------------
module pse_front
    import pse_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  logic                   in_start,
    output logic                   item_valid,
    input  logic                   item_ready,
    output logic [VALUE_WIDTH-1:0] item_value,
    output logic                   item_start
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // entry: start flag above the value
    logic [VALUE_WIDTH:0] q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push, pop;

    assign in_ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;
    assign item_value = q_mem[rd_ptr_reg][VALUE_WIDTH-1:0];
    assign item_start = q_mem[rd_ptr_reg][VALUE_WIDTH];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= {in_start, in_value};
        end
    end

endmodule

// ===== hdl/pse_engine.sv =====
// ----------------------------------------------------------------------------
// pse_engine
// Monotonic stack sequencer: pops entries not smaller than the new value,
// reports the remaining top and pushes the value into the stack memory unless it is full.
// ----------------------------------------------------------------------------
`include "previous_smaller_element_core_defines.svh"

module pse_engine
    import pse_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [VALUE_WIDTH-1:0] item_value,
    input  logic                   item_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_found,
    output logic [VALUE_WIDTH-1:0] out_prev,
    output logic                   out_overflow
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]       rd_addr, wr_addr;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, ovf_reg;
    logic [VALUE_WIDTH-1:0] prev_reg;

    logic top_ge, out_free, out_load, push, stack_full, stack_empty;

    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign top_ge      = !stack_empty && ($signed(top_reg) >= $signed(cur_reg));
    assign out_free    = !out_valid_reg || out_ready;
    // entry below the current top, valid in the cycle after a pop
    assign rd_addr     = IDX_W'(count_reg - CNT_W'(2));
    assign wr_addr     = count_reg[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        item_ready = 1'b0;
        out_load   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    item_ready = 1'b1;
                    cur_next   = item_value;
                    if (item_start) begin
                        count_next = '0;
                    end
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (top_ge) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RD;
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (!stack_full) begin
                        push       = 1'b1;
                        count_next = count_reg + 1'b1;
                        top_next   = cur_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_RD: begin
                top_next   = rd_data_reg;
                state_next = S_CMP;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        top_reg <= top_next;
        if (out_load) begin
            found_reg <= !stack_empty;
            prev_reg  <= stack_empty ? '0 : top_reg;
            ovf_reg   <= stack_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[wr_addr] <= cur_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = found_reg;
    assign out_prev     = prev_reg;
    assign out_overflow = ovf_reg;

    `PSE_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    `PSE_ASSERT_NEXT(a_pop_step, aclk, aresetn, state_reg == S_CMP && top_ge, state_reg == S_RD && count_reg == $past(count_reg) - 1'b1)
    `PSE_ASSERT_NEXT(a_ovf_keeps_full, aclk, aresetn, out_load && stack_full, out_overflow && count_reg == CNT_W'(STACK_DEPTH))

endmodule

// ===== hdl/previous_smaller_element_core.sv =====
// ----------------------------------------------------------------------------
// previous_smaller_element_core
// Streaming previous strictly smaller element finder on a monotonic stack.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata carries a signed value, tuser[0] is the start
// flag that empties the stack so the value begins a new sequence.
// Output stream m_axis: one transaction per input, tdata is the nearest
// earlier strictly smaller value (zero if none), tuser[0] says one was found,
// tuser[1] says the stack was full and the value was not pushed.
// Inputs land in a four-entry queue; the stack engine takes them one at a
// time. Every stack entry that an item pops costs a refetch of the new top
// from the stack memory through its registered read port. Each value is
// popped at most once.
// Reset empties the queue, the stack and the output register; stack memory
// needs no clearing pass. When m_axis_tready is low the result holds, the
// engine stalls at its next result and the queue fills before s_axis_tready
// drops.
// ----------------------------------------------------------------------------
module previous_smaller_element_core
    import pse_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // value
    input  logic [0:0]                            s_axis_tuser,  // start_req
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // prev_smaller
    output logic [1:0]                            m_axis_tuser   // found, overflow
);

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic                   item_valid, item_ready, item_start;
    logic [VALUE_WIDTH-1:0] item_value;
    logic                   found, overflow;
    logic [VALUE_WIDTH-1:0] prev_smaller;

    pse_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_value   (s_axis_tdata[VALUE_WIDTH-1:0]),
        .in_start   (s_axis_tuser[IN_START_BIT]),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_value (item_value),
        .item_start (item_start)
    );

    pse_engine #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_value   (item_value),
        .item_start   (item_start),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_found    (found),
        .out_prev     (prev_smaller),
        .out_overflow (overflow)
    );

    assign m_axis_tdata                = TDATA_W'(prev_smaller);
    assign m_axis_tuser[OUT_FOUND_BIT] = found;
    assign m_axis_tuser[OUT_OVF_BIT]   = overflow;

endmodule

// ===== bench/tb_previous_smaller_element_core.sv =====
// ----------------------------------------------------------------------------
// tb_previous_smaller_element_core
// Self-checking bench for the streaming previous smaller element core. A
// short directed list hits the value extremes, equal values, -1 and restarts.
// A full-length ramp then overflows the stack, and random runs of several
// shapes follow: random, narrow, rising, falling, sawtooth and the odd ramp. A monotonic
// stack kept in the bench predicts every result, and results are checked in
// order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_previous_smaller_element_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pse_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int SD           = STACK_DEPTH_DEF;
    localparam int DW           = ((VW + 7) / 8) * 8;
    localparam int N_ITEMS      = 1950;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED   = 17;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;
    typedef enum logic [2:0] {
        RUN_RANDOM, RUN_NARROW, RUN_RISE, RUN_FALL, RUN_SAW, RUN_RAMP
    } run_shape_t;

    typedef struct packed {
        logic          found;
        logic [VW-1:0] prev;
        logic          ovf;
    } smaller_result_t;

    class smaller_scoreboard;
        logic signed [VW-1:0] stack_mem [SD];
        int                   depth      = 0;
        int                   max_depth  = 0;
        int                   n_found    = 0;
        int                   n_ovf      = 0;
        int                   n_checked  = 0;
        int                   errors     = 0;
        smaller_result_t      pending[$];

        // accepted input transaction: run the monotonic stack and queue the result
        function void note_input(logic [VW-1:0] value, logic start);
            smaller_result_t      r;
            logic signed [VW-1:0] v;
            v = value;
            if (start)
                depth = 0;
            while (depth > 0 && stack_mem[depth-1] >= v)
                depth--;
            r.found = (depth > 0);
            r.prev  = (depth > 0) ? stack_mem[depth-1] : '0;
            r.ovf   = (depth == SD);
            if (depth < SD) begin
                stack_mem[depth] = v;
                depth++;
            end
            if (depth > max_depth)
                max_depth = depth;
            n_found += r.found;
            n_ovf   += r.ovf;
            pending = {pending, r};
        endfunction

        function void check_result(logic [DW-1:0] data, logic [1:0] user);
            smaller_result_t want;
            smaller_result_t got;
            got.found = user[OUT_FOUND_BIT];
            got.ovf   = user[OUT_OVF_BIT];
            got.prev  = data[VW-1:0];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result transaction: found=%0b prev=%0d ovf=%0b",
                             got.found, $signed(got.prev), got.ovf);
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found || got.prev !== want.prev || got.ovf !== want.ovf) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"mismatch on result %0d: expected found=%0b prev=%0d ovf=%0b,",
                              " got found=%0b prev=%0d ovf=%0b"},
                             n_checked, want.found, $signed(want.prev), want.ovf,
                             got.found, $signed(got.prev), got.ovf);
            end
            n_checked++;
        endfunction
    endclass

    logic          aclk          = 1'b0;
    logic          aresetn       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata  = '0;   // value
    logic [0:0]    s_axis_tuser  = '0;   // start_req
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;         // prev_smaller
    logic [1:0]    m_axis_tuser;         // found, overflow

    smaller_scoreboard sb;
    int                n_sent     = 0;
    int                n_runs     = 0;
    int                burst_left = 0;
    int                idle_count = 0;
    rx_mode_t          rx_mode    = RX_ALWAYS;
    int                rx_left    = 0;

    localparam logic [VW-1:0] DIR_VALUE [N_DIRECTED] = '{
        16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000,
        16'h7FFF, 16'h7FFF, 16'h7FFE, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
        16'h7FFF, 16'h0000, 16'hFFFE
    };
    localparam bit DIR_START [N_DIRECTED] = '{
        1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1, 0
    };

    previous_smaller_element_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watch both channels, predict on input and check on output
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata[VW-1:0], s_axis_tuser[IN_START_BIT]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver stalls, switching between a few patterns
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= int'($urandom_range(20, 200));
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= ((rx_left % 8) < 3);
        endcase
    end

    task automatic send_item(input logic [VW-1:0] value, input logic start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(value);
        s_axis_tuser[IN_START_BIT] <= start;
        do @(posedge aclk); while (!s_axis_tready);
        n_sent++;
        if (start)
            n_runs++;
    endtask

    task automatic play_run(input run_shape_t shape, input int len, input logic first_start);
        int            cur;
        logic [VW-1:0] v;
        logic          st;
        case (shape)
            RUN_RISE: cur = -32768 + int'($urandom_range(0, 20000));
            RUN_FALL: cur = 32767 - int'($urandom_range(0, 20000));
            RUN_RAMP: cur = -32768 + int'($urandom_range(0, 2000));
            default:  cur = int'($urandom_range(0, 65535)) - 32768;
        endcase
        for (int i = 0; i < len; i++) begin
            case (shape)
                RUN_RISE: cur += int'($urandom_range(0, 700)) - 150;
                RUN_FALL: cur -= int'($urandom_range(0, 700)) - 150;
                RUN_RAMP: cur += int'($urandom_range(0, 150));
                RUN_SAW: begin
                    // slow climb with an occasional deep drop
                    if ($urandom_range(0, 15) == 0)
                        cur -= int'($urandom_range(2000, 30000));
                    else
                        cur += int'($urandom_range(0, 400));
                end
                default: ;
            endcase
            if (cur > 32767)
                cur = 32767;
            if (cur < -32768)
                cur = -32768;
            case (shape)
                RUN_RANDOM: v = VW'($urandom);
                RUN_NARROW: v = VW'(int'($urandom_range(0, 8)) - 4);
                default:    v = VW'(cur);
            endcase
            // a stray restart now and then, never inside the ramp
            if (i == 0)
                st = first_start;
            else
                st = (shape != RUN_RAMP) && ($urandom_range(0, 59) == 0);
            send_item(v, st);
        end
    endtask

    initial begin
        int r;
        sb = new;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIR_VALUE[i], DIR_START[i]);
        // long ramp to fill the stack and run past its depth
        play_run(RUN_RAMP, SD + 44, 1'b1);

        while (n_sent < N_ITEMS) begin
            r = $urandom_range(0, 39);
            if (r == 0)
                play_run(RUN_RAMP, $urandom_range(SD + 2, SD + 64),
                         $urandom_range(0, 9) != 0);
            else
                play_run(run_shape_t'(r % 5), $urandom_range(1, 60),
                         $urandom_range(0, 9) != 0);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d values in %0d restarted runs, checked %0d results",
                 n_sent, n_runs, sb.n_checked);
        $display("%0d results had a smaller predecessor, %0d hit a full stack, deepest stack %0d",
                 sb.n_found, sb.n_ovf, sb.max_depth);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pse_pkg.sv
hdl/pse_front.sv
hdl/pse_engine.sv
hdl/previous_smaller_element_core.sv
bench/tb_previous_smaller_element_core.sv
